FILE: hw/rtl/xoshiro256ss_range_generator_macros.svh
// Assertion macros shared by the range generator modules.
`ifndef XOSHIRO256SS_RANGE_GENERATOR_MACROS_SVH
`define XOSHIRO256SS_RANGE_GENERATOR_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define XRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/xrg_pkg.sv
// Package with types, codes, constants and generator functions of the range generator.
package xrg_pkg;

  // Request codes.
  localparam logic [1:0] OP_SEED     = 2'd0;
  localparam logic [1:0] OP_FRACTION = 2'd1;
  localparam logic [1:0] OP_RANGE    = 2'd2;
  localparam logic [1:0] OP_RAW      = 2'd3;

  // Warm-up steps after a seed load, and the counter that covers them.
  localparam int WARMUP_STEPS = 16;
  localparam int WARM_W       = $clog2(WARMUP_STEPS + 1);

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Fixed seed loaded at reset, and the fixed word 1 of a seed load.
  localparam logic [63:0] RESET_WORD0 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] RESET_WORD1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] RESET_WORD2 = 64'h94d049bb133111eb;
  localparam logic [63:0] RESET_WORD3 = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] SEED_WORD1  = 64'h00000000000000ff;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] first_operand;
    logic signed [63:0] second_operand;
  } req_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic signed [63:0] echo_second;
    logic               status;
  } rsp_word_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] first;
    logic [63:0] second;
    logic [63:0] span;
    logic [63:0] cover_mask;
    logic        empty;
  } cmd_t;

  typedef logic [3:0][63:0] gen_state_t;

  // One xoshiro256 state step.
  function automatic gen_state_t gen_step(gen_state_t s);
    logic [63:0] w2;
    logic [63:0] w3;
    gen_state_t  n;
    w2   = s[2] ^ s[0];
    w3   = s[3] ^ s[1];
    n[0] = s[0] ^ w3;
    n[1] = s[1] ^ w2;
    n[2] = w2 ^ {s[1][46:0], 17'b0};
    n[3] = {w3[18:0], w3[63:19]};
    return n;
  endfunction

  // First half of the star-star scrambler: times five.
  function automatic logic [63:0] mul5(logic [63:0] x);
    return {x[61:0], 2'b00} + x;
  endfunction

  // Second half: rotate left by seven, then times nine.
  function automatic logic [63:0] rot7_mul9(logic [63:0] x);
    logic [63:0] r;
    r = {x[56:0], x[63:57]};
    return {r[60:0], 3'b000} + r;
  endfunction

endpackage

FILE: hw/rtl/xrg_front.sv
// Front end: takes request words, classifies them and pushes commands.
module xrg_front
  import xrg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      push,
  input  logic      full,
  output cmd_t      cmd
);

  logic        held;
  req_word_t   word;
  logic [63:0] span;
  logic [63:0] cover_mask;

  // All-ones cover of a span: smear the top set bit downward.
  function automatic logic [63:0] cover_of(logic [63:0] x);
    logic [63:0] c;
    c = x;
    c = c | (c >> 1);
    c = c | (c >> 2);
    c = c | (c >> 4);
    c = c | (c >> 8);
    c = c | (c >> 16);
    c = c | (c >> 32);
    return c;
  endfunction

  assign push      = held && !full;
  assign req_ready = !held || !full;

  // Input holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_valid && req_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (req_valid && req_ready) begin
      word <= req;
    end
  end

  // Classification of the held word.
  always_comb begin
    span       = $unsigned(word.second_operand) - $unsigned(word.first_operand);
    cover_mask = cover_of(span);
    cmd.op     = word.op;
    cmd.first  = word.first_operand;
    cmd.second = word.second_operand;
    cmd.span   = span;
    cmd.cover_mask = cover_mask;
    cmd.empty  = (word.op == OP_RANGE) && (word.first_operand > word.second_operand);
  end

endmodule

FILE: hw/rtl/xrg_queue.sv
// Short command queue between the front and the back.
`include "xoshiro256ss_range_generator_macros.svh"
module xrg_queue
  import xrg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  // Pointer and fill count upkeep.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  `XRG_ASSERT_NEXT(a_fill_up, push && !pop, count == $past(count) + 1'b1, "queue fill count missed a push")
  `XRG_ASSERT_NEXT(a_fill_down, pop && !push, count == $past(count) - 1'b1, "queue fill count missed a pop")

endmodule

FILE: hw/rtl/xrg_back.sv
// Back end: generator state, draw sequencer, range rejection and result register.
`include "xoshiro256ss_range_generator_macros.svh"
module xrg_back
  import xrg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  cmd_t      head,
  output logic      pop,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_SCRAMBLE,
    ST_CHECK
  } state_t;

  state_t            state;
  gen_state_t        gen;
  cmd_t              cur;
  logic [63:0]       prod;
  logic [63:0]       draw;
  logic [WARM_W-1:0] warm_cnt;
  logic [63:0]       masked;
  logic              reject;
  logic              out_free;
  logic              write;
  rsp_word_t         result;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !rsp_valid || rsp_ready;
  assign masked   = draw & cur.cover_mask;
  assign reject   = (cur.op == OP_RANGE) && !cur.empty && (masked > cur.span);

  // Result word for a finished draw or seed.
  always_comb begin
    result.value       = '0;
    result.echo_second = '0;
    result.status      = 1'b0;
    unique case (cur.op)
      OP_SEED: begin
        result.value       = cur.first;
        result.echo_second = cur.second;
      end
      OP_FRACTION: begin
        result.value = {11'b0, draw[63:11]};
      end
      OP_RAW: begin
        result.value = draw;
      end
      OP_RANGE: begin
        if (cur.empty) begin
          result.status = 1'b1;
        end else begin
          result.value = cur.first + masked;
        end
      end
      default: begin
        result.value = '0;
      end
    endcase
  end

  // A result leaves when the sequencer is done and the output register is free.
  always_comb begin
    write = 1'b0;
    unique case (state)
      ST_WARM:  write = (warm_cnt == '0) && out_free;
      ST_CHECK: write = !reject && out_free;
      default:  write = 1'b0;
    endcase
  end

  // Sequencer, generator state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      gen       <= {RESET_WORD3, RESET_WORD2, RESET_WORD1, RESET_WORD0};
    end else begin
      if (write) begin
        rsp_valid <= 1'b1;
        rsp       <= result;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            cur <= head;
            if (head.op == OP_SEED) begin
              gen      <= {64'h0, head.second, SEED_WORD1, head.first};
              warm_cnt <= WARM_W'(WARMUP_STEPS);
              state    <= ST_WARM;
            end else begin
              gen   <= gen_step(gen);
              prod  <= mul5(gen[1]);
              state <= ST_SCRAMBLE;
            end
          end
        end
        ST_WARM: begin
          if (warm_cnt != '0) begin
            gen      <= gen_step(gen);
            warm_cnt <= warm_cnt - 1'b1;
          end else if (write) begin
            state <= ST_IDLE;
          end
        end
        ST_SCRAMBLE: begin
          draw  <= rot7_mul9(prod);
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (reject) begin
            gen   <= gen_step(gen);
            prod  <= mul5(gen[1]);
            state <= ST_SCRAMBLE;
          end else if (write) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `XRG_ASSERT_NEXT(a_scramble_to_check, state == ST_SCRAMBLE, state == ST_CHECK,
    "scramble did not lead to check")
  `XRG_ASSERT_NOW(a_check_entry, state == ST_CHECK,
    ($past(state) == ST_SCRAMBLE) || ($past(state) == ST_CHECK),
    "check entered from a wrong state")
  `XRG_ASSERT_NEXT(a_warm_count, (state == ST_WARM) && (warm_cnt != '0),
    warm_cnt == $past(warm_cnt) - 1'b1, "warm-up counter skipped a step")

endmodule

FILE: hw/rtl/xoshiro256ss_range_generator.sv
// Top level of the xoshiro256** range generator: front, queue and back.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_word_t  (op, first_operand, second_operand)
//   rsp      out        rsp_valid / rsp_ready  rsp_word_t  (value, echo_second, status)
//
// A fraction, raw or range word passes through the back-end states SCRAMBLE and CHECK after
// it leaves the queue, and every rejected range draw goes back to SCRAMBLE; the scrambler is
// split over two registered adds (prod, then draw) and the rejection test is made in CHECK.
// A seed word makes WARMUP_STEPS generator steps in WARM, one generator step per warm-up cycle.
// The front holds one word and the queue two commands, so requests keep arriving while
// the back end works or waits on a stalled response.
// Reset (rst, synchronous) empties the pipeline and loads the fixed seed.
module xoshiro256ss_range_generator
  import xrg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  logic push;
  logic full;
  logic pop;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head;

  xrg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push      (push),
    .full      (full),
    .cmd       (push_cmd)
  );

  xrg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  xrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
